// ===== hdl/ucs_pkg.sv =====
// Types, status codes and constants shared by the unit connection status machine.
`default_nettype none

package ucs_pkg;

    localparam int unsigned TimeWidth   = 32;
    localparam int unsigned CodeWidth   = 4;
    localparam int unsigned StateWidth  = 11;
    localparam int unsigned InDataWidth  = 40;
    localparam int unsigned OutDataWidth = 8;

    localparam logic [TimeWidth-1:0] TimeoutReset = 32'd15;

    // Requested mount mode
    localparam logic [1:0] MODE_UNMOUNT = 2'd0;
    localparam logic [1:0] MODE_RO      = 2'd1;
    localparam logic [1:0] MODE_RW      = 2'd2;

    // Reported status codes
    localparam logic [CodeWidth-1:0] CODE_NOTPRESENT   = 4'd0;
    localparam logic [CodeWidth-1:0] CODE_FAILURE      = 4'd1;
    localparam logic [CodeWidth-1:0] CODE_DISCONNECTED = 4'd2;
    localparam logic [CodeWidth-1:0] CODE_TRYCONN_RO   = 4'd3;
    localparam logic [CodeWidth-1:0] CODE_TRYCONN_RW   = 4'd4;
    localparam logic [CodeWidth-1:0] CODE_CONN_RO      = 4'd5;
    localparam logic [CodeWidth-1:0] CODE_CONN_RW      = 4'd6;
    localparam logic [CodeWidth-1:0] CODE_RECONN_RO    = 4'd7;
    localparam logic [CodeWidth-1:0] CODE_RECONN_RW    = 4'd8;
    localparam logic [CodeWidth-1:0] CODE_TRYDISC_RO   = 4'd9;
    localparam logic [CodeWidth-1:0] CODE_TRYDISC_RW   = 4'd10;

    typedef enum logic [StateWidth-1:0] {
        ST_NOTPRESENT   = 11'b000_0000_0001,
        ST_FAILURE      = 11'b000_0000_0010,
        ST_DISCONNECTED = 11'b000_0000_0100,
        ST_TRYCONN_RO   = 11'b000_0000_1000,
        ST_TRYCONN_RW   = 11'b000_0001_0000,
        ST_CONN_RO      = 11'b000_0010_0000,
        ST_CONN_RW      = 11'b000_0100_0000,
        ST_RECONN_RO    = 11'b000_1000_0000,
        ST_RECONN_RW    = 11'b001_0000_0000,
        ST_TRYDISC_RO   = 11'b010_0000_0000,
        ST_TRYDISC_RW   = 11'b100_0000_0000
    } state_t;

    typedef struct packed {
        logic                 present;
        logic                 connected;
        logic [1:0]           mount_mode;
        logic [TimeWidth-1:0] now;
    } item_t;

    typedef struct packed {
        logic [TimeWidth-1:0] connect_start_time;
        logic [TimeWidth-1:0] disconnect_time;
    } times_t;

    typedef struct packed {
        state_t state;
        times_t times;
        logic   changed;
    } step_t;

    function automatic logic [CodeWidth-1:0] state_code(input state_t st);
        logic [CodeWidth-1:0] code;
        case (st)
            ST_NOTPRESENT:   code = CODE_NOTPRESENT;
            ST_FAILURE:      code = CODE_FAILURE;
            ST_DISCONNECTED: code = CODE_DISCONNECTED;
            ST_TRYCONN_RO:   code = CODE_TRYCONN_RO;
            ST_TRYCONN_RW:   code = CODE_TRYCONN_RW;
            ST_CONN_RO:      code = CODE_CONN_RO;
            ST_CONN_RW:      code = CODE_CONN_RW;
            ST_RECONN_RO:    code = CODE_RECONN_RO;
            ST_RECONN_RW:    code = CODE_RECONN_RW;
            ST_TRYDISC_RO:   code = CODE_TRYDISC_RO;
            ST_TRYDISC_RW:   code = CODE_TRYDISC_RW;
            default:         code = CODE_NOTPRESENT;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/unit_connection_status_fsm.sv =====
// Top level of the unit connection status machine: input register, step logic, result register.
//
// Usage
//   s_* channel : one evaluation item per handshake (presence, link flag, requested
//                 mount mode, current time). Accepted when s_tvalid and s_tready are high.
//   m_* channel : exactly one result item per evaluation: the new status code and a
//                 flag that is set when the status moved.
//   cfg_*       : write channel for the connect / reconnect timeout. Always ready;
//                 write it only while no evaluation is in flight.
// Flow and throughput
//   An item is captured in the input register, evaluated by the step logic and
//   lands in the result register, whose valid drives m_tvalid. One item is taken
//   every clock while m_tready keeps the result register draining; the status and the
//   two timestamps are updated by the same edge that loads the result register, so a
//   following item always sees the state left by the one before it.
// Reset
//   rst_n low clears the status to not present, both timestamps to zero, the timeout
//   to fifteen and empties both registers.
// Stall
//   When m_tready is low the result register holds its item; the input register still
//   takes one more item, after which s_tready drops until the result is taken.
`default_nettype none

module unit_connection_status_fsm (
    input  var logic                                clk,
    input  var logic                                rst_n,
    // [0] present, [1] connected, [3:2] mount_mode, [35:4] now, [39:36] zero
    input  var logic [ucs_pkg::InDataWidth-1:0]     s_tdata,
    input  var logic                                s_tvalid,
    output var logic                                s_tready,
    // [3:0] status, [4] changed, [7:5] zero
    output var logic [ucs_pkg::OutDataWidth-1:0]    m_tdata,
    output var logic                                m_tvalid,
    input  var logic                                m_tready,
    input  var logic [ucs_pkg::TimeWidth-1:0]       cfg_data,
    input  var logic                                cfg_valid,
    output var logic                                cfg_ready
);

    logic                                in_valid_reg;
    ucs_pkg::item_t                      in_item_reg;
    logic                                out_valid_reg;
    logic [ucs_pkg::CodeWidth-1:0]       out_status_reg;
    logic                                out_changed_reg;
    ucs_pkg::state_t                     state_reg;
    ucs_pkg::times_t                     times_reg;
    logic [ucs_pkg::TimeWidth-1:0]       timeout_reg;
    ucs_pkg::step_t                      step;
    logic                                advance;
    logic                                fire;
    logic                                s_accept;

    // Result register frees when empty or being taken; input register frees when
    // empty or when its item moves on
    assign advance   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    ucs_step u_step (
        .state        (state_reg),
        .times        (times_reg),
        .wait_timeout (timeout_reg),
        .item         (in_item_reg),
        .result       (step)
    );

    // Input register: hold the item until the result register can take its result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.present    <= s_tdata[0];
            in_item_reg.connected  <= s_tdata[1];
            in_item_reg.mount_mode <= s_tdata[3:2];
            in_item_reg.now        <= s_tdata[35:4];
        end
    end

    // Status, timestamps and timeout
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ucs_pkg::ST_NOTPRESENT;
            times_reg   <= '0;
            timeout_reg <= ucs_pkg::TimeoutReset;
        end
        else
        begin
            if (fire)
            begin
                state_reg <= step.state;
                times_reg <= step.times;
            end
            if (cfg_valid)
                timeout_reg <= cfg_data;
        end
    end

    // Result register: advance on fire, drop the valid once the item is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_status_reg  <= ucs_pkg::state_code(step.state);
            out_changed_reg <= step.changed;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_changed_reg, out_status_reg};

    // An evaluated item always lands in the result register
    a_fire_lands: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("evaluated item did not reach the result register");

    // The changed flag agrees with the stored status transition
    a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (out_changed_reg == (state_reg != $past(state_reg))))
        else $error("changed flag disagrees with status transition");

    // The disconnect timestamp is only live in a reconnect state
    a_disc_time_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ucs_pkg::ST_RECONN_RO && state_reg != ucs_pkg::ST_RECONN_RW)
        |-> (times_reg.disconnect_time == '0))
        else $error("disconnect time left set outside reconnect");

    // An absent unit drops to not present unless connected or reconnecting
    a_absent_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !in_item_reg.present &&
         state_reg != ucs_pkg::ST_CONN_RO && state_reg != ucs_pkg::ST_CONN_RW &&
         state_reg != ucs_pkg::ST_RECONN_RO && state_reg != ucs_pkg::ST_RECONN_RW)
        |=> (state_reg == ucs_pkg::ST_NOTPRESENT))
        else $error("absent unit did not drop to not present");

endmodule

`default_nettype wire

// ===== hdl/ucs_step.sv =====
// Next-status and timestamp logic for one evaluation item.
`default_nettype none

module ucs_step (
    input  var ucs_pkg::state_t                   state,
    input  var ucs_pkg::times_t                   times,
    input  var logic [ucs_pkg::TimeWidth-1:0]     wait_timeout,
    input  var ucs_pkg::item_t                    item,
    output var ucs_pkg::step_t                    result
);

    logic [ucs_pkg::TimeWidth-1:0] conn_elapsed;
    logic [ucs_pkg::TimeWidth-1:0] disc_elapsed;
    logic                          conn_expired;
    logic                          disc_expired;
    ucs_pkg::state_t               state_next;
    ucs_pkg::times_t               times_next;

    // Elapsed times wrap modulo 2^32
    assign conn_elapsed = item.now - times.connect_start_time;
    assign disc_elapsed = item.now - times.disconnect_time;
    assign conn_expired = (conn_elapsed >= wait_timeout);
    assign disc_expired = (disc_elapsed > wait_timeout);

    always_comb
    begin
        state_next = state;
        times_next = times;
        if (!item.present)
        begin
            // Connected and reconnect states ride out an absence
            if (state != ucs_pkg::ST_CONN_RO && state != ucs_pkg::ST_CONN_RW &&
                state != ucs_pkg::ST_RECONN_RO && state != ucs_pkg::ST_RECONN_RW)
            begin
                state_next = ucs_pkg::ST_NOTPRESENT;
            end
        end
        else
        begin
            case (state)
                ucs_pkg::ST_NOTPRESENT:
                begin
                    state_next = ucs_pkg::ST_DISCONNECTED;
                end
                ucs_pkg::ST_DISCONNECTED:
                begin
                    if (item.mount_mode == ucs_pkg::MODE_RO)
                    begin
                        state_next = ucs_pkg::ST_TRYCONN_RO;
                        times_next.connect_start_time = item.now;
                    end
                    else if (item.mount_mode == ucs_pkg::MODE_RW)
                    begin
                        state_next = ucs_pkg::ST_TRYCONN_RW;
                        times_next.connect_start_time = item.now;
                    end
                end
                ucs_pkg::ST_TRYCONN_RO:
                begin
                    if (item.connected)
                        state_next = ucs_pkg::ST_CONN_RO;
                    else if (conn_expired)
                        state_next = ucs_pkg::ST_TRYDISC_RO;
                end
                ucs_pkg::ST_TRYCONN_RW:
                begin
                    if (item.connected)
                        state_next = ucs_pkg::ST_CONN_RW;
                    else if (conn_expired)
                        state_next = ucs_pkg::ST_TRYDISC_RW;
                end
                ucs_pkg::ST_CONN_RO:
                begin
                    if (!item.connected)
                    begin
                        state_next = ucs_pkg::ST_RECONN_RO;
                        times_next.disconnect_time = item.now;
                    end
                    else if (item.mount_mode != ucs_pkg::MODE_RO)
                    begin
                        state_next = ucs_pkg::ST_TRYDISC_RO;
                    end
                end
                ucs_pkg::ST_CONN_RW:
                begin
                    if (!item.connected)
                    begin
                        state_next = ucs_pkg::ST_RECONN_RW;
                        times_next.disconnect_time = item.now;
                    end
                    else if (item.mount_mode != ucs_pkg::MODE_RW)
                    begin
                        state_next = ucs_pkg::ST_TRYDISC_RW;
                    end
                end
                ucs_pkg::ST_RECONN_RO:
                begin
                    if (item.connected)
                    begin
                        state_next = ucs_pkg::ST_CONN_RO;
                        times_next.disconnect_time = '0;
                    end
                    else if (disc_expired || item.mount_mode == ucs_pkg::MODE_UNMOUNT)
                    begin
                        state_next = ucs_pkg::ST_TRYDISC_RO;
                        times_next.disconnect_time = '0;
                    end
                end
                ucs_pkg::ST_RECONN_RW:
                begin
                    if (item.connected)
                    begin
                        state_next = ucs_pkg::ST_CONN_RW;
                        times_next.disconnect_time = '0;
                    end
                    else if (disc_expired || item.mount_mode == ucs_pkg::MODE_UNMOUNT)
                    begin
                        state_next = ucs_pkg::ST_TRYDISC_RW;
                        times_next.disconnect_time = '0;
                    end
                end
                ucs_pkg::ST_TRYDISC_RO, ucs_pkg::ST_TRYDISC_RW:
                begin
                    if (!item.connected)
                        state_next = ucs_pkg::ST_DISCONNECTED;
                end
                default:
                begin
                    // Failure holds while the unit is present
                    state_next = state;
                end
            endcase
        end
    end

    assign result.state   = state_next;
    assign result.times   = times_next;
    assign result.changed = (state_next != state);

endmodule

`default_nettype wire
